### rtl/und_pkg.sv
`default_nettype none
package und_pkg;

  // default fraction bits of the outputs
  localparam int FRAC_BITS = 14;

  // packed word layout
  localparam int WORD_W  = 16;
  localparam int CODE_W  = 7;
  localparam int SQ_W    = 14;
  localparam int OUT_W   = 16;

  localparam int SIGN_X  = 15;
  localparam int SIGN_Y  = 14;
  localparam int SIGN_Z  = 13;

  localparam logic [CODE_W-1:0] CODE_MAX = 7'd127;
  localparam logic [CODE_W:0]   Z_BASE   = 8'd126;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [2:0]        signs_t;

endpackage
`default_nettype wire

### rtl/und_front.sv
`default_nettype none
module und_front (
  input  wire logic                        clk,
  input  wire logic [1:0]                  en,
  input  wire logic [und_pkg::WORD_W-1:0]  word_i,
  output und_pkg::sq_t                     xsq_o,
  output und_pkg::sq_t                     ysq_o,
  output und_pkg::sq_t                     zsq_o,
  output und_pkg::sq_t                     len2_o
);

  und_pkg::code_t x_w, y_w, z_w, xm_w, ym_w;
  logic [und_pkg::CODE_W:0] s_w, s2_w;
  und_pkg::code_t x_r, y_r, z_r;
  und_pkg::sq_t   xsq_w, ysq_w, zsq_w;
  logic [und_pkg::SQ_W+1:0] len_w;
  und_pkg::sq_t   xsq_r, ysq_r, zsq_r, len2_r;

  // unpack, mirror the upper triangle and derive z
  always_comb begin
    x_w  = {1'b0, word_i[12:7]};
    y_w  = word_i[6:0];
    s_w  = {1'b0, x_w} + {1'b0, y_w};
    xm_w = (s_w >= {1'b0, und_pkg::CODE_MAX}) ? (und_pkg::CODE_MAX - x_w) : x_w;
    ym_w = (s_w >= {1'b0, und_pkg::CODE_MAX}) ? (und_pkg::CODE_MAX - y_w) : y_w;
    s2_w = {1'b0, xm_w} + {1'b0, ym_w};
    z_w  = (s2_w <= und_pkg::Z_BASE) ? und_pkg::CODE_W'(und_pkg::Z_BASE - s2_w) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= xm_w;
      y_r <= ym_w;
      z_r <= z_w;
    end
  end

  // squares and squared length
  always_comb begin
    xsq_w = x_r * x_r;
    ysq_w = y_r * y_r;
    zsq_w = z_r * z_r;
    len_w = {2'b00, xsq_w} + {2'b00, ysq_w} + {2'b00, zsq_w};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xsq_r  <= xsq_w;
      ysq_r  <= ysq_w;
      zsq_r  <= zsq_w;
      len2_r <= len_w[und_pkg::SQ_W-1:0];
    end
  end

  assign xsq_o  = xsq_r;
  assign ysq_o  = ysq_r;
  assign zsq_o  = zsq_r;
  assign len2_o = len2_r;

endmodule
`default_nettype wire

### rtl/und_div.sv
`default_nettype none
module und_div #(
  parameter int FRAC_BITS = und_pkg::FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic [2*FRAC_BITS+2:0]    en,
  input  wire und_pkg::sq_t              c2_i,
  input  wire und_pkg::sq_t              len2_i,
  output logic [2*FRAC_BITS+2:0]         quo_o
);

  localparam int NDIV = 2 * FRAC_BITS + 3;
  localparam int LW   = und_pkg::SQ_W;

  logic [LW-1:0]   rem_r [NDIV];
  logic [LW-1:0]   len_r [NDIV];
  logic [NDIV-1:0] quo_r [NDIV];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_stage
    logic [LW:0]     t_w;
    logic [LW-1:0]   l_w;
    logic [NDIV-1:0] qp_w;
    logic [LW:0]     diff_w;
    logic            ge_w;

    if (k == 0) begin : g_first
      assign t_w  = {1'b0, c2_i};
      assign l_w  = len2_i;
      assign qp_w = '0;
    end else begin : g_rest
      assign t_w  = {rem_r[k-1], 1'b0};
      assign l_w  = len_r[k-1];
      assign qp_w = quo_r[k-1];
    end

    assign ge_w   = t_w >= {1'b0, l_w};
    assign diff_w = t_w - {1'b0, l_w};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge_w ? diff_w[LW-1:0] : t_w[LW-1:0];
        len_r[k] <= l_w;
        quo_r[k] <= {qp_w[NDIV-2:0], ge_w};
      end
    end
  end

  assign quo_o = quo_r[NDIV-1];

endmodule
`default_nettype wire

### rtl/und_sqrt.sv
`default_nettype none
module und_sqrt #(
  parameter int FRAC_BITS = und_pkg::FRAC_BITS
) (
  input  wire logic                    clk,
  input  wire logic [FRAC_BITS+1:0]    en,
  input  wire logic [2*FRAC_BITS+2:0]  d_i,
  output logic [FRAC_BITS+1:0]         root_o
);

  localparam int NSQ = FRAC_BITS + 2;
  localparam int SW  = 2 * NSQ;
  localparam int RW  = FRAC_BITS + 3;

  logic [SW-1:0]  d_r    [NSQ];
  logic [RW-1:0]  rem_r  [NSQ];
  logic [NSQ-1:0] root_r [NSQ];

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_stage
    logic [SW-1:0]  dp_w;
    logic [RW-1:0]  rp_w;
    logic [NSQ-1:0] op_w;
    logic [RW+1:0]  r4_w;
    logic [RW+1:0]  trial_w;
    logic [RW+1:0]  diff_w;
    logic           ge_w;

    if (k == 0) begin : g_first
      assign dp_w = {1'b0, d_i};
      assign rp_w = '0;
      assign op_w = '0;
    end else begin : g_rest
      assign dp_w = d_r[k-1];
      assign rp_w = rem_r[k-1];
      assign op_w = root_r[k-1];
    end

    assign r4_w    = {rp_w, dp_w[SW-1:SW-2]};
    assign trial_w = {1'b0, op_w, 2'b01};
    assign ge_w    = r4_w >= trial_w;
    assign diff_w  = r4_w - trial_w;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        d_r[k]    <= {dp_w[SW-3:0], 2'b00};
        rem_r[k]  <= ge_w ? diff_w[RW-1:0] : r4_w[RW-1:0];
        root_r[k] <= {op_w[NSQ-2:0], ge_w};
      end
    end
  end

  assign root_o = root_r[NSQ-1];

endmodule
`default_nettype wire

### rtl/unit_normal_16bit_decode.sv
`default_nettype none
// Decoder for 16-bit packed unit normals. Each transfer on the in_ channel carries
// one packed word (three sign bits, a 6-bit x code and a 7-bit y code); each
// transfer on the out_ channel carries the unit vector as three signed fixed-point
// components with FRAC_BITS fraction bits, rounded to nearest with ties away from
// zero and saturated to 16 bits. The block is a linear pipeline of
// 3*FRAC_BITS + 8 register stages (50 at the default of 14): two stages unpack
// and square, 2*FRAC_BITS + 3 stages of restoring division form c^2 * 4^(F+1) /
// len^2, FRAC_BITS + 2 stages take the integer square root, one stage rounds.
// A new word is taken every cycle while in_stall is low. Bubbles are
// squeezed out, so in_stall only rises once every stage holds an item and the
// result at the output is stalled.
module unit_normal_16bit_decode #(
  parameter int FRAC_BITS = und_pkg::FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [und_pkg::WORD_W-1:0] in_packed_normal,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [und_pkg::OUT_W-1:0] out_nx,
  output logic signed [und_pkg::OUT_W-1:0] out_ny,
  output logic signed [und_pkg::OUT_W-1:0] out_nz
);

  // stage budget
  localparam int NDIV = 2 * FRAC_BITS + 3;
  localparam int NSQ  = FRAC_BITS + 2;
  localparam int DIV0 = 2;
  localparam int SQ0  = DIV0 + NDIV;
  localparam int NST  = SQ0 + NSQ + 1;
  localparam int EW   = NSQ + 17;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  und_pkg::signs_t sg_r [NST];

  und_pkg::sq_t sq_w [3];
  und_pkg::sq_t len2_w;
  logic [NDIV-1:0] quo_w  [3];
  logic [NSQ-1:0]  root_w [3];

  logic [NSQ:0]    rnd_w [3];
  logic [EW-1:0]   mag_w [3];
  logic [und_pkg::OUT_W-1:0] res_w [3];
  logic [und_pkg::OUT_W-1:0] res_r [3];

  // a stage may load when empty or when the stage after it moves on
  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // sign bits ride alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sg_r[0] <= {in_packed_normal[und_pkg::SIGN_X], in_packed_normal[und_pkg::SIGN_Y],
                  in_packed_normal[und_pkg::SIGN_Z]};
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        sg_r[k] <= sg_r[k-1];
      end
    end
  end

  und_front u_front (
    .clk    (clk),
    .en     (en[1:0]),
    .word_i (in_packed_normal),
    .xsq_o  (sq_w[0]),
    .ysq_o  (sq_w[1]),
    .zsq_o  (sq_w[2]),
    .len2_o (len2_w)
  );

  // one division and one root lane per component
  for (genvar c = 0; c < 3; c++) begin : g_lane
    und_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .en     (en[DIV0 +: NDIV]),
      .c2_i   (sq_w[c]),
      .len2_i (len2_w),
      .quo_o  (quo_w[c])
    );

    und_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clk    (clk),
      .en     (en[SQ0 +: NSQ]),
      .d_i    (quo_w[c]),
      .root_o (root_w[c])
    );

    // root is floor(2 * value); halve with round up, then sign and saturate
    always_comb begin
      rnd_w[c] = {1'b0, root_w[c]} + 1'b1;
      mag_w[c] = {17'd0, rnd_w[c][NSQ:1]};
      if (sg_r[NST-2][2-c]) begin
        res_w[c] = (mag_w[c] > EW'(32768)) ? 16'h8000 : (16'd0 - mag_w[c][15:0]);
      end else begin
        res_w[c] = (mag_w[c] > EW'(32767)) ? 16'h7fff : mag_w[c][15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[NST-1]) begin
        res_r[c] <= res_w[c];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_nx    = res_r[0];
  assign out_ny    = res_r[1];
  assign out_nz    = res_r[2];

endmodule
`default_nettype wire

### rtl/und_chk.sv
`default_nettype none
module und_chk #(
  parameter int FRAC_BITS = und_pkg::FRAC_BITS
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [und_pkg::WORD_W-1:0]  in_packed_normal,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [und_pkg::OUT_W-1:0]   out_nx,
  input wire logic [und_pkg::OUT_W-1:0]   out_ny,
  input wire logic [und_pkg::OUT_W-1:0]   out_nz
);

  localparam int F_CHK = FRAC_BITS;

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // input only held back when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // stalled input word holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_packed_normal)))
    else $error("stalled input word changed");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_nx) && $stable(out_ny)
                                  && $stable(out_nz)))
    else $error("stalled result changed");

  // a unit vector is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n || F_CHK < 0)
    out_valid |-> (out_nx != '0 || out_ny != '0 || out_nz != '0))
    else $error("zero vector");

endmodule

bind unit_normal_16bit_decode und_chk #(.FRAC_BITS(FRAC_BITS)) u_und_chk (.*);
`default_nettype wire
